@@ design/assert_macros.svh @@
// Shared assertion macros for the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("concurrent assertion failed");

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`endif

@@ design/pngu_pkg.sv @@
package pngu_pkg;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;
    localparam int ROW_WIDTH_W     = 11;
    localparam int HEIGHT_W        = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [1:0] channel;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } t_result;

    function automatic logic [8:0] abs10(logic signed [9:0] v);
        logic signed [9:0] n;
        n = -v;
        return v[9] ? n[8:0] : v[8:0];
    endfunction

    function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [8:0] da;
        logic [8:0] db;
        logic [8:0] dc;
        da = abs10($signed({2'b00, b}) - $signed({2'b00, c}));
        db = abs10($signed({2'b00, a}) - $signed({2'b00, c}));
        dc = abs10($signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0}));
        if (da <= db && da <= dc) begin
            return a;
        end else if (db <= dc) begin
            return b;
        end
        return c;
    endfunction

    function automatic logic [7:0] predict(t_filter f, logic [7:0] a, logic [7:0] b,
                                           logic [7:0] c);
        logic [8:0] sum;
        logic [7:0] p;
        sum = {1'b0, a} + {1'b0, b};
        unique case (f)
            FILT_SUB:   p = a;
            FILT_UP:    p = b;
            FILT_AVG:   p = sum[8:1];
            FILT_PAETH: p = paeth_pick(a, b, c);
            default:    p = 8'd0;
        endcase
        return p;
    endfunction

endpackage

@@ design/pngu_line_store.sv @@
module pngu_line_store #(
    parameter int MAX_WIDTH = pngu_pkg::DEF_MAX_WIDTH
) (
    input  logic                                                    i_clk,
    input  logic                                                    i_we,
    input  logic [$clog2(MAX_WIDTH*pngu_pkg::BYTES_PER_PIXEL)-1:0]  i_waddr,
    input  logic [7:0]                                              i_wdata,
    input  logic [$clog2(MAX_WIDTH*pngu_pkg::BYTES_PER_PIXEL)-1:0]  i_raddr,
    output logic [7:0]                                              o_rdata
);
    import pngu_pkg::*;

    localparam int DEPTH = MAX_WIDTH * BYTES_PER_PIXEL;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/pngu_skid.sv @@
module pngu_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pngu_pkg::t_result i_res,
    output logic              o_full,
    output logic              o_valid,
    output pngu_pkg::t_result o_res,
    input  logic              i_ready
);
    import pngu_pkg::*;

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_v || pop) begin
                r_out   <= i_res;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= i_res;
                r_skid_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

@@ design/png_scanline_unfilter_unit.sv @@
// Reconstructs filtered PNG scanlines for 8-bit RGBA, non-interlaced images, taking one
// inflated byte per beat at a sustained rate of one beat per clock cycle when not stalled.
// Each sample beat's result is registered in the output register, or in the skid register
// if that is occupied; filter-type beats yield nothing unless the type is invalid, which
// gives one error beat and silently consumes the rest of the image. The input is stalled
// only when both the output register and the skid register hold undelivered beats. The
// previous row lives in a line store of MAX_WIDTH*4 bytes with one write and one
// registered read port each cycle; it is not cleared at reset, and row 0 of every image
// never reads it. Writing either register restarts parsing at the filter byte of row 0.
`include "assert_macros.svh"

module png_scanline_unfilter_unit #(
    parameter int MAX_WIDTH = pngu_pkg::DEF_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pngu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pngu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_data_byte,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [7:0]                      o_pixel_byte,
    output logic [1:0]                      o_channel,
    output logic                            o_row_end,
    output logic                            o_image_end,
    output logic                            o_bad_filter
);
    import pngu_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * BYTES_PER_PIXEL;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(DEPTH + 1);

    logic [POS_W-1:0]    r_pos,      n_pos;
    logic [POS_W-1:0]    r_stride,   n_stride;
    logic [HEIGHT_W-1:0] r_row,      n_row;
    logic [HEIGHT_W-1:0] r_last_row, n_last_row;
    t_filter             r_filter,   n_filter;
    logic                r_disc,     n_disc;
    logic [7:0]          r_left [BYTES_PER_PIXEL];
    logic [7:0]          n_left [BYTES_PER_PIXEL];
    logic [7:0]          r_ul   [BYTES_PER_PIXEL];
    logic [7:0]          n_ul   [BYTES_PER_PIXEL];

    logic              accept;
    logic              skid_full;
    logic              push;
    t_result           res;
    t_result           out_res;
    logic [POS_W-1:0]  x;
    logic [1:0]        ch;
    logic [7:0]        a_byte;
    logic [7:0]        b_byte;
    logic [7:0]        c_byte;
    logic [7:0]        val;
    logic [7:0]        rd_data;
    logic              last_in_row;
    logic              last_in_image;
    logic              mem_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       cfg_w;
    logic [31:0]       eff_w;
    logic [HEIGHT_W-1:0] cfg_h;

    assign o_ready = !skid_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        x             = r_pos - POS_W'(1);
        ch            = x[1:0];
        a_byte        = r_left[ch];
        b_byte        = (r_row != '0) ? rd_data : 8'd0;
        c_byte        = (r_row != '0) ? r_ul[ch] : 8'd0;
        val           = i_data_byte + predict(r_filter, a_byte, b_byte, c_byte);
        last_in_row   = r_pos >= r_stride;
        last_in_image = last_in_row && (r_row >= r_last_row);

        cfg_w = 32'(i_cfg_data[ROW_WIDTH_W-1:0]);
        if (cfg_w == 32'd0) begin
            eff_w = 32'd1;
        end else if (cfg_w > 32'(MAX_WIDTH)) begin
            eff_w = 32'(MAX_WIDTH);
        end else begin
            eff_w = cfg_w;
        end
        cfg_h = (i_cfg_data[HEIGHT_W-1:0] == '0) ? HEIGHT_W'(1) : i_cfg_data[HEIGHT_W-1:0];

        n_pos      = r_pos;
        n_stride   = r_stride;
        n_row      = r_row;
        n_last_row = r_last_row;
        n_filter   = r_filter;
        n_disc     = r_disc;
        n_left     = r_left;
        n_ul       = r_ul;
        push       = 1'b0;
        mem_we     = 1'b0;
        res        = '0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_WIDTH:    n_stride   = POS_W'(eff_w * 32'(BYTES_PER_PIXEL));
                CFG_IMAGE_HEIGHT: n_last_row = cfg_h - HEIGHT_W'(1);
                default:          n_stride   = r_stride;
            endcase
            n_pos    = '0;
            n_row    = '0;
            n_filter = FILT_NONE;
            n_disc   = 1'b0;
            n_left   = '{default: 8'd0};
            n_ul     = '{default: 8'd0};
        end else if (accept) begin
            if (r_pos == '0) begin
                n_left = '{default: 8'd0};
                n_ul   = '{default: 8'd0};
                n_pos  = POS_W'(1);
                if (!r_disc) begin
                    if (i_data_byte > 8'(FILT_PAETH)) begin
                        n_disc         = 1'b1;
                        push           = 1'b1;
                        res.bad_filter = 1'b1;
                    end else begin
                        n_filter = t_filter'(i_data_byte[2:0]);
                    end
                end
            end else begin
                n_left[ch] = val;
                n_ul[ch]   = b_byte;
                mem_we     = !r_disc;
                if (last_in_row) begin
                    n_pos = '0;
                    if (last_in_image) begin
                        n_row  = '0;
                        n_disc = 1'b0;
                    end else begin
                        n_row = r_row + HEIGHT_W'(1);
                    end
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
                push           = !r_disc;
                res.pixel_byte = val;
                res.channel    = ch;
                res.row_end    = last_in_row;
                res.image_end  = last_in_image;
            end
        end

        // The store is read one beat ahead, at the column of the next sample beat.
        rd_addr = (n_pos == '0) ? '0 : ADDR_W'(n_pos - POS_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_stride   <= POS_W'(BYTES_PER_PIXEL);
            r_row      <= '0;
            r_last_row <= '0;
            r_filter   <= FILT_NONE;
            r_disc     <= 1'b0;
            r_left     <= '{default: 8'd0};
            r_ul       <= '{default: 8'd0};
        end else begin
            r_pos      <= n_pos;
            r_stride   <= n_stride;
            r_row      <= n_row;
            r_last_row <= n_last_row;
            r_filter   <= n_filter;
            r_disc     <= n_disc;
            r_left     <= n_left;
            r_ul       <= n_ul;
        end
    end

    pngu_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (x[ADDR_W-1:0]),
        .i_wdata (val),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    pngu_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_full  (skid_full),
        .o_valid (o_valid),
        .o_res   (out_res),
        .i_ready (i_ready)
    );

    assign o_pixel_byte = out_res.pixel_byte;
    assign o_channel    = out_res.channel;
    assign o_row_end    = out_res.row_end;
    assign o_image_end  = out_res.image_end;
    assign o_bad_filter = out_res.bad_filter;

    `ASSERT_NEVER(a_pos_in_row, i_clk, i_rst_n, r_pos > r_stride)
    `ASSERT_CLK(a_bad_clean, i_clk, i_rst_n,
        (o_valid && o_bad_filter) |-> (o_pixel_byte == 8'd0 && !o_row_end && !o_image_end))
    `ASSERT_CLK(a_bad_discards, i_clk, i_rst_n,
        (accept && !i_cfg_we && r_pos == '0 && !r_disc && i_data_byte > 8'(FILT_PAETH)) |=> r_disc)
    `ASSERT_NEVER(a_no_write_discard, i_clk, i_rst_n, mem_we && r_disc)

endmodule
